FILE: design/vtm_pkg.sv
package vtm_pkg;

   localparam int DEFAULT_MAX_DOMAINS = 16;

   localparam int TIME_W   = 64;
   localparam int DOMAIN_W = 4;
   localparam int LOAD_W   = 32;
   localparam int KIND_W   = 2;
   localparam int CSR_W    = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [LOAD_W-1:0] MAX_LOAD_RESET = '1;

   // Request kinds.
   localparam logic [KIND_W-1:0] REQ_ARM     = 2'd0;
   localparam logic [KIND_W-1:0] REQ_REMOVE  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_SERVICE = 2'd2;

   // Result kinds.
   localparam logic [KIND_W-1:0] RES_EXPIRED = 2'd0;
   localparam logic [KIND_W-1:0] RES_LOAD    = 2'd1;
   localparam logic [KIND_W-1:0] RES_REFUSED = 2'd2;
   localparam logic [KIND_W-1:0] RES_IDLE    = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LEAD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LOAD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITE,
      ST_DUE,
      ST_MIN,
      ST_UPDATE,
      ST_EMIT_EXP,
      ST_LOAD,
      ST_EMIT_LAST
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] sum;
      logic              due;
   } alu_result_type;

endpackage

FILE: design/vtm_time_alu.sv
module vtm_time_alu
   import vtm_pkg::*;
(
   input  logic [TIME_W-1:0] op_a,
   input  logic [TIME_W-1:0] op_b,
   input  logic              subtract,
   input  logic [CSR_W-1:0]  min_lead,
   output alu_result_type    result
);

   logic [TIME_W-1:0] b_eff;
   logic [TIME_W-1:0] sum;

   assign b_eff = subtract ? ~op_b : op_b;
   assign sum   = op_a + b_eff + {{(TIME_W-1){1'b0}}, subtract};

   // A distance is due when it lies within the lead window or is negative,
   // which means the deadline has already passed.
   assign result.sum = sum;
   assign result.due = sum[TIME_W-1]
                       || ((sum[TIME_W-1:CSR_W] == '0) && (sum[CSR_W-1:0] <= min_lead));

endmodule

FILE: design/virtual_timer_multiplexer_core.sv
// Each request walks the timer table with one shared 64-bit adder. Remove and refused arm run
// one lookup pass; service runs a due pass, then min passes with an expiry response after each
// due entry found, then a load pass; arm runs a lookup pass, writes its slot and then does what
// service does; an unused kind goes straight to its last response. Response stalls hold the block,
// and it returns to idle before it takes the next request. Reset clears the armed marks and loads the
// configuration defaults; table contents stay undefined until written and no clearing pass runs.
module virtual_timer_multiplexer_core
   import vtm_pkg::*;
#(
   parameter int MAX_DOMAINS = DEFAULT_MAX_DOMAINS
)
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [KIND_W-1:0]      req_kind,
   input  logic [DOMAIN_W-1:0]    req_domain,
   input  logic [TIME_W-1:0]      req_now_time,
   input  logic [TIME_W-1:0]      req_delay,
   input  logic [TIME_W-1:0]      req_repeat_period,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [KIND_W-1:0]      rsp_result_kind,
   output logic [DOMAIN_W-1:0]    rsp_expired_domain,
   output logic [LOAD_W-1:0]      rsp_load_value,
   output logic                   rsp_last,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

   localparam int AW      = $clog2(MAX_DOMAINS);
   localparam int CW      = $clog2(MAX_DOMAINS + 1);
   localparam int ENTRY_W = DOMAIN_W + 2 * TIME_W;
   localparam logic [CW-1:0] SCAN_END = CW'(MAX_DOMAINS);

   state_type state_ff, state_in;

   logic [CSR_W-1:0] min_lead_ff;
   logic [CSR_W-1:0] max_load_ff;

   logic [KIND_W-1:0]   kind_ff;
   logic [DOMAIN_W-1:0] domain_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   delay_ff;
   logic [TIME_W-1:0]   period_ff;

   // Entry layout: owner, deadline, period.
   logic [ENTRY_W-1:0] table_mem [MAX_DOMAINS];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [MAX_DOMAINS-1:0] armed_ff;
   logic [MAX_DOMAINS-1:0] due_ff;

   logic [CW-1:0] scan_ff;
   logic          eval_valid_ff;
   logic [AW-1:0] eval_idx_ff;

   logic          match_found_ff, free_found_ff;
   logic [AW-1:0] match_idx_ff, free_idx_ff;

   logic                best_found_ff;
   logic [AW-1:0]       best_idx_ff;
   logic [TIME_W-1:0]   best_key_ff;
   logic [DOMAIN_W-1:0] best_owner_ff;
   logic [TIME_W-1:0]   best_period_ff;

   logic              any_ff;
   logic [TIME_W-1:0] rt_ff;

   logic [KIND_W-1:0]   res_kind_ff;
   logic [DOMAIN_W-1:0] res_domain_ff;
   logic [LOAD_W-1:0]   res_load_ff;
   logic                res_last_ff;

   logic                in_pass;
   logic                enter;
   logic                pass_done;
   logic [DOMAIN_W-1:0] ent_owner;
   logic [TIME_W-1:0]   ent_deadline;
   logic [TIME_W-1:0]   ent_period;
   logic [TIME_W-1:0]   alu_a, alu_b;
   logic                alu_sub;
   alu_result_type      alu_res;
   logic [TIME_W-1:0]   key;
   logic [AW-1:0]       slot_idx;
   logic [LOAD_W-1:0]   clamped;

   assign ent_owner    = rd_data_ff[ENTRY_W-1 -: DOMAIN_W];
   assign ent_deadline = rd_data_ff[2*TIME_W-1 -: TIME_W];
   assign ent_period   = rd_data_ff[TIME_W-1:0];

   assign in_pass   = (state_ff == ST_LOOKUP) || (state_ff == ST_DUE)
                      || (state_ff == ST_MIN) || (state_ff == ST_LOAD);
   assign enter     = (state_in != state_ff);
   assign pass_done = (scan_ff == SCAN_END) && !eval_valid_ff;

   // Signed order of the distance becomes unsigned order with the top bit flipped.
   assign key      = {~alu_res.sum[TIME_W-1], alu_res.sum[TIME_W-2:0]};
   assign slot_idx = match_found_ff ? match_idx_ff : free_idx_ff;
   assign clamped  = ((rt_ff[TIME_W-1:LOAD_W] != '0) || (rt_ff[LOAD_W-1:0] > max_load_ff))
                     ? max_load_ff : rt_ff[LOAD_W-1:0];

   vtm_time_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .subtract (alu_sub),
      .min_lead (min_lead_ff),
      .result   (alu_res)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind) inside
                  REQ_ARM, REQ_REMOVE: state_in = ST_LOOKUP;
                  REQ_SERVICE:         state_in = ST_DUE;
                  default:             state_in = ST_EMIT_LAST;
               endcase
            end
         end
         ST_LOOKUP: begin
            if (pass_done) begin
               if (kind_ff == REQ_REMOVE)
                  state_in = ST_EMIT_LAST;
               else if (match_found_ff || free_found_ff)
                  state_in = ST_WRITE;
               else
                  state_in = ST_EMIT_LAST;
            end
         end
         ST_WRITE: state_in = ST_DUE;
         ST_DUE: begin
            if (pass_done)
               state_in = ST_MIN;
         end
         ST_MIN: begin
            if (pass_done)
               state_in = best_found_ff ? ST_UPDATE : ST_LOAD;
         end
         ST_UPDATE: state_in = ST_EMIT_EXP;
         ST_EMIT_EXP: begin
            if (rsp_ready)
               state_in = ST_MIN;
         end
         ST_LOAD: begin
            if (pass_done)
               state_in = ST_EMIT_LAST;
         end
         ST_EMIT_LAST: begin
            if (rsp_ready)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs, adder operands and table writes.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT_EXP) || (state_ff == ST_EMIT_LAST);
      alu_a     = ent_deadline;
      alu_b     = now_ff;
      alu_sub   = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = best_idx_ff;
      mem_wdata = {best_owner_ff, alu_res.sum, best_period_ff};
      unique case (state_ff)
         ST_WRITE: begin
            alu_a     = now_ff;
            alu_b     = delay_ff;
            alu_sub   = 1'b0;
            mem_we    = 1'b1;
            mem_waddr = slot_idx;
            mem_wdata = {domain_ff, alu_res.sum, period_ff};
         end
         ST_UPDATE: begin
            alu_a   = now_ff;
            alu_b   = best_period_ff;
            alu_sub = 1'b0;
            mem_we  = (best_period_ff != '0);
         end
         default: begin
         end
      endcase
   end

   assign rsp_result_kind    = res_kind_ff;
   assign rsp_expired_domain = res_domain_ff;
   assign rsp_load_value     = res_load_ff;
   assign rsp_last           = res_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         min_lead_ff   <= '0;
         max_load_ff   <= MAX_LOAD_RESET;
         scan_ff       <= '0;
         eval_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MIN_LEAD: min_lead_ff <= csr_data;
               CSR_MAX_LOAD: max_load_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (enter) begin
            scan_ff       <= '0;
            eval_valid_ff <= 1'b0;
         end else if (in_pass && (scan_ff != SCAN_END)) begin
            scan_ff       <= scan_ff + CW'(1);
            eval_valid_ff <= 1'b1;
         end else begin
            eval_valid_ff <= 1'b0;
         end
      end
   end

   // Table memory with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we)
         table_mem[mem_waddr] <= mem_wdata;
      rd_data_ff  <= table_mem[scan_ff[AW-1:0]];
      eval_idx_ff <= scan_ff[AW-1:0];
   end

   // Armed and due marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         due_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_LOOKUP: begin
               if (eval_valid_ff && (kind_ff == REQ_REMOVE) && armed_ff[eval_idx_ff]
                   && (ent_owner == domain_ff))
                  armed_ff[eval_idx_ff] <= 1'b0;
            end
            ST_WRITE: armed_ff[slot_idx] <= 1'b1;
            ST_DUE: begin
               if (eval_valid_ff)
                  due_ff[eval_idx_ff] <= armed_ff[eval_idx_ff] && alu_res.due;
            end
            ST_UPDATE: begin
               due_ff[best_idx_ff] <= 1'b0;
               if (best_period_ff == '0)
                  armed_ff[best_idx_ff] <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Request capture and per-pass search registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         kind_ff   <= req_kind;
         domain_ff <= req_domain;
         now_ff    <= req_now_time;
         delay_ff  <= req_delay;
         period_ff <= req_repeat_period;
      end

      if (enter && state_in == ST_LOOKUP) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
      end else if (state_ff == ST_LOOKUP && eval_valid_ff) begin
         if (armed_ff[eval_idx_ff] && (ent_owner == domain_ff) && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= eval_idx_ff;
         end
         if (!armed_ff[eval_idx_ff] && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= eval_idx_ff;
         end
      end

      // Ties keep the lower slot because the scan runs upward with a strict compare.
      if (enter && state_in == ST_MIN) begin
         best_found_ff <= 1'b0;
      end else if (state_ff == ST_MIN && eval_valid_ff && due_ff[eval_idx_ff]
                   && (!best_found_ff || (key < best_key_ff))) begin
         best_found_ff  <= 1'b1;
         best_idx_ff    <= eval_idx_ff;
         best_key_ff    <= key;
         best_owner_ff  <= ent_owner;
         best_period_ff <= ent_period;
      end

      if (enter && state_in == ST_LOAD) begin
         any_ff <= 1'b0;
      end else if (state_ff == ST_LOAD && eval_valid_ff && armed_ff[eval_idx_ff]
                   && (!any_ff || (alu_res.sum < rt_ff))) begin
         any_ff <= 1'b1;
         rt_ff  <= alu_res.sum;
      end

      if (enter && state_in == ST_EMIT_EXP) begin
         res_kind_ff   <= RES_EXPIRED;
         res_domain_ff <= best_owner_ff;
         res_load_ff   <= '0;
         res_last_ff   <= 1'b0;
      end else if (enter && state_in == ST_EMIT_LAST) begin
         res_domain_ff <= '0;
         res_last_ff   <= 1'b1;
         if (state_ff == ST_LOOKUP && kind_ff != REQ_REMOVE) begin
            res_kind_ff <= RES_REFUSED;
            res_load_ff <= '0;
         end else if (state_ff == ST_LOAD && any_ff) begin
            res_kind_ff <= RES_LOAD;
            res_load_ff <= clamped;
         end else begin
            res_kind_ff <= RES_IDLE;
            res_load_ff <= '0;
         end
      end
   end

endmodule
